/* sv/path_conflict_detector_defines.svh */
// Assertion macros for the path conflict detector
`ifndef PATH_CONFLICT_DETECTOR_DEFINES_SVH
`define PATH_CONFLICT_DETECTOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pcd_pkg.sv */
// Shared types and constants of the path conflict detector
`timescale 1ns / 1ps
package pcd_pkg;
    localparam int DEFAULT_MAX_AGENTS = 32;
    localparam int TIME_W = 16;
    localparam int AGENT_W = 5;
    localparam int LOC_W = 20;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 72;
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_EDGE = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  time_step;
        logic [AGENT_W-1:0] agent_id;
        logic [LOC_W-1:0]   location;
    } pcd_item_t;
endpackage

/* sv/path_conflict_detector.sv */
// The scan takes one item at a time; each earlier agent costs a store read and a compare.
// Conflicts leave through a single output register.
// Reset (rst_n, async low) clears control state; the location store is not cleared.
`timescale 1ns / 1ps
// Top level of the path conflict detector
module path_conflict_detector #(
    parameter int MAX_AGENTS = pcd_pkg::DEFAULT_MAX_AGENTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // time_step[15:0], agent_id[20:16], location[40:21], zero pad
    input  logic [pcd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // first_agent, second_agent, first_location, second_location, conflict_time, pad
    output logic [pcd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // conflict_kind
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);
    import pcd_pkg::*;

    logic      q_valid;
    logic      q_pop;
    pcd_item_t q_item;

    pcd_front #(.MAX_AGENTS(MAX_AGENTS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    pcd_back #(.MAX_AGENTS(MAX_AGENTS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );
endmodule

/* sv/pcd_front.sv */
// Input side: accepts words, drops out-of-range agents, queues the rest
`timescale 1ns / 1ps
module pcd_front #(
    parameter int MAX_AGENTS = pcd_pkg::DEFAULT_MAX_AGENTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pcd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            q_valid,
    output pcd_pkg::pcd_item_t              q_item,
    input  logic                            q_pop
);
    import pcd_pkg::*;

    localparam int DEPTH = 2;

    pcd_item_t       fifo_reg [DEPTH];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    pcd_item_t       in_item;
    logic            in_ok;
    logic            push;

    assign in_item.time_step = s_axis_tdata[15:0];
    assign in_item.agent_id  = s_axis_tdata[20:16];
    assign in_item.location  = s_axis_tdata[40:21];

    assign in_ok = 32'(in_item.agent_id) < 32'(MAX_AGENTS);
    assign s_axis_tready = cnt_reg != 2'(DEPTH);
    assign push = s_axis_tvalid && s_axis_tready && in_ok;
    assign q_valid = cnt_reg != 2'd0;
    assign q_item = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= in_item;
    end
endmodule

/* sv/pcd_back.sv */
// Scan side: location store, vertex and swap scans, output word register
`timescale 1ns / 1ps
module pcd_back #(
    parameter int MAX_AGENTS = pcd_pkg::DEFAULT_MAX_AGENTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  pcd_pkg::pcd_item_t              q_item,
    output logic                            q_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pcd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);
    import pcd_pkg::*;
    `include "path_conflict_detector_defines.svh"

    localparam int DEPTH = 2 * MAX_AGENTS;
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_FROM, S_FROM_CAP, S_V_RD, S_V_CMP, S_E_RD, S_E_CMP, S_FLUSH, S_WRITE
    } state_t;

    logic [LOC_W-1:0]   mem [DEPTH];
    logic [LOC_W-1:0]   rd_a_reg, rd_b_reg;
    logic [AW-1:0]      addr_a, addr_b;
    logic               rd_en, mem_we;

    state_t             state_reg, state_next;
    pcd_item_t          item_reg, item_next;
    logic [LOC_W-1:0]   from_reg, from_next;
    logic               edge_en_reg, edge_en_next;
    logic [AGENT_W-1:0] b_reg, b_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_kind_reg, pend_kind_next;
    logic [AGENT_W-1:0] pend_agent_reg, pend_agent_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    logic               out_last_reg, out_last_next;
    logic [65:0]        out_data_reg, out_data_next;

    logic               out_free, out_push, out_last;
    logic               cur_bank;
    logic [AW-1:0]      cur_base, prev_base;
    logic               match;

    assign cur_bank = item_reg.time_step[0];
    assign cur_base = cur_bank ? AW'(MAX_AGENTS) : '0;
    assign prev_base = cur_bank ? '0 : AW'(MAX_AGENTS);
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        from_next = from_reg;
        edge_en_next = edge_en_reg;
        b_next = b_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next = pend_kind_reg;
        pend_agent_next = pend_agent_reg;
        rd_en = 1'b0;
        mem_we = 1'b0;
        q_pop = 1'b0;
        out_push = 1'b0;
        out_last = 1'b0;
        addr_a = cur_base + AW'(b_reg);
        addr_b = prev_base + AW'(b_reg);
        match = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_next = q_item;
                    edge_en_next = q_item.time_step != '0;
                    b_next = '0;
                    pend_valid_next = 1'b0;
                    state_next = S_FROM;
                end
            end
            S_FROM:
            begin
                rd_en = 1'b1;
                addr_a = prev_base + AW'(item_reg.agent_id);
                state_next = S_FROM_CAP;
            end
            S_FROM_CAP:
            begin
                from_next = rd_a_reg;
                edge_en_next = edge_en_reg && (rd_a_reg != item_reg.location);
                state_next = S_V_RD;
            end
            S_V_RD:
            begin
                if (b_reg == item_reg.agent_id)
                begin
                    b_next = '0;
                    state_next = S_E_RD;
                end
                else
                begin
                    rd_en = 1'b1;
                    state_next = S_V_CMP;
                end
            end
            S_E_RD:
            begin
                if (!edge_en_reg || b_reg == item_reg.agent_id)
                    state_next = S_FLUSH;
                else
                begin
                    rd_en = 1'b1;
                    state_next = S_E_CMP;
                end
            end
            S_V_CMP, S_E_CMP:
            begin
                if (state_reg == S_V_CMP)
                    match = rd_a_reg == item_reg.location;
                else
                    match = (rd_b_reg == item_reg.location) && (rd_a_reg == from_reg);
                if (!match || !pend_valid_reg || out_free)
                begin
                    if (match)
                    begin
                        out_push = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_kind_next = (state_reg == S_E_CMP) ? KIND_EDGE : KIND_VERTEX;
                        pend_agent_next = b_reg;
                    end
                    b_next = b_reg + 1'b1;
                    state_next = (state_reg == S_V_CMP) ? S_V_RD : S_E_RD;
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = S_WRITE;
                else if (out_free)
                begin
                    out_push = 1'b1;
                    out_last = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
                addr_a = cur_base + AW'(item_reg.agent_id);
                q_pop = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;
        out_data_next = out_data_reg;
        if (out_push)
        begin
            out_valid_next = 1'b1;
            out_kind_next = pend_kind_reg;
            out_last_next = out_last;
            out_data_next = {item_reg.time_step,
                             (pend_kind_reg == KIND_EDGE) ? from_reg : LOC_W'(0),
                             item_reg.location, item_reg.agent_id, pend_agent_reg};
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        from_reg <= from_next;
        edge_en_reg <= edge_en_next;
        b_reg <= b_next;
        pend_kind_reg <= pend_kind_next;
        pend_agent_reg <= pend_agent_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_a] <= item_reg.location;
        if (rd_en)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {6'd0, out_data_reg};
    assign m_axis_tuser = out_kind_reg;
    assign m_axis_tlast = out_last_reg;

    `PCD_ASSERT_SAME(a_idle_no_pend, state_reg == S_IDLE, !pend_valid_reg, "pending in idle")
    `PCD_ASSERT_SAME(a_push_free, out_push, out_free, "output overwritten")
    `PCD_ASSERT_SAME(a_pop_valid, q_pop, q_valid, "pop of empty queue")
    `PCD_ASSERT_NEXT(a_flush_done, state_reg == S_WRITE, !pend_valid_reg, "result lost")
endmodule
